FILE: sv/extended_gcd_bezout_top_assert.svh
// Assertion macros used by the checker file.
`ifndef EXTENDED_GCD_BEZOUT_TOP_ASSERT_SVH
`define EXTENDED_GCD_BEZOUT_TOP_ASSERT_SVH

// Consequent checked on the clock after the antecedent.
`define EGB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent checked on the same clock as the antecedent.
`define EGB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: sv/egcd_pkg.sv
`default_nettype none
package egcd_pkg;

	// Operand width and derived widths
	localparam int WIDTH  = 32;
	localparam int CW     = WIDTH + 1;
	localparam int CNT_W  = $clog2(WIDTH);
	localparam int STW    = 2 * WIDTH;
	localparam int MRAW   = 2 * CW + WIDTH;
	localparam int MTW    = ((MRAW + 7) / 8) * 8;
	localparam int MPAD   = MTW - MRAW;

	// One row of the algorithm: coefficients of u and v, and the remainder
	typedef struct packed {
		logic [CW-1:0]    a;
		logic [CW-1:0]    b;
		logic [WIDTH-1:0] r;
	} triple_t;

	// Finished result handed from the core to the output register
	typedef struct packed {
		logic [WIDTH-1:0] divisor;
		logic [CW-1:0]    coef_v;
		logic [CW-1:0]    coef_u;
	} res_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

FILE: sv/egcd_shsub.sv
`default_nettype none
module egcd_shsub
	import egcd_pkg::*;
(
	input  triple_t          acc,
	input  triple_t          dvs,
	input  logic [CNT_W-1:0] sh,
	output triple_t          nxt
);

	logic [STW-1:0] wide;
	logic           take;

	// Shift the divisor row, compare against the running remainder
	always_comb begin
		wide = {{WIDTH{1'b0}}, dvs.r} << sh;
		take = (wide[STW-1:WIDTH] == '0) && (wide[WIDTH-1:0] <= acc.r);
	end

	// Subtract the shifted row when the quotient bit is set
	always_comb begin
		if (take) begin
			nxt.r = acc.r - wide[WIDTH-1:0];
			nxt.a = acc.a - (dvs.a << sh);
			nxt.b = acc.b - (dvs.b << sh);
		end else begin
			nxt = acc;
		end
	end

endmodule
`default_nettype wire

FILE: sv/egcd_core.sv
`default_nettype none
module egcd_core
	import egcd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] operand_u,
	input  logic [WIDTH-1:0] operand_v,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	triple_t          t0_q, t1_q;
	triple_t          nxt;
	logic             div_last;

	egcd_shsub u_shsub (
		.acc (t0_q),
		.dvs (t1_q),
		.sh  (cnt_q),
		.nxt (nxt)
	);

	// Decode outputs from the state
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		res_valid = (state_q == ST_DONE);
		div_last  = (cnt_q == '0);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (operand_v == '0) ? ST_DONE : ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_last && (nxt.r == '0)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold the state and the bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE || (state_q == ST_DIV && div_last)) begin
				cnt_q <= CNT_W'(WIDTH - 1);
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Load the rows, reduce the remainder a bit a cycle, rotate at the end
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			t0_q.a <= CW'(1);
			t0_q.b <= '0;
			t0_q.r <= operand_u;
			t1_q.a <= '0;
			t1_q.b <= CW'(1);
			t1_q.r <= operand_v;
		end else if (state_q == ST_DIV) begin
			if (div_last) begin
				t0_q <= t1_q;
				t1_q <= nxt;
			end else begin
				t0_q <= nxt;
			end
		end
	end

	assign res.coef_u  = t0_q.a;
	assign res.coef_v  = t0_q.b;
	assign res.divisor = t0_q.r;

endmodule
`default_nettype wire

FILE: sv/extended_gcd_bezout_top.sv
// Channel  Direction  tdata fields (lowest bit up)
// s_*      in         operand_u[31:0], operand_v[63:32]
// m_*      out        coef_u[32:0], coef_v[65:33], divisor[97:66], zero pad to 104
//
// A request is loaded, runs through division steps on the one shift-subtract
// unit, each working down the quotient bits, and is handed off; the step
// count is data dependent.
// s_tready is high only while the sequencer is idle; a finished result moves
// to the output register when that is empty, so a new request can be taken
// while m_tready is low. arst_n clears the sequencer and the output valid flag.
`default_nettype none
module extended_gcd_bezout_top
	import egcd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [STW-1:0] s_tdata,   // operand_u, operand_v
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [MTW-1:0] m_tdata    // coef_u, coef_v, divisor, zero pad
);

	logic res_valid, res_ready;
	res_t res, out_q;
	logic out_valid_q;

	egcd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.operand_u (s_tdata[WIDTH-1:0]),
		.operand_v (s_tdata[STW-1:WIDTH]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_tready;

	// Hold the result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{MPAD{1'b0}}, out_q};

endmodule
`default_nettype wire

FILE: sv/egcd_chk.sv
`default_nettype none
`include "extended_gcd_bezout_top_assert.svh"
module egcd_chk
	import egcd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  logic           s_tready,
	input  logic           m_tvalid,
	input  logic           m_tready,
	input  logic [MTW-1:0] m_tdata
);

	// A taken request keeps the block busy on the next cycle
	`EGB_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "request not followed by busy")

	// A stalled result holds
	`EGB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

	// A new result only follows a cycle in which the block was busy
	`EGB_ASSERT_SAME(a_res_from_busy, $rose(m_tvalid), !$past(s_tready), "result appeared while idle")

	// Padding stays clear
	`EGB_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[MTW-1:MRAW] == '0, "padding bits set")

endmodule

bind extended_gcd_bezout_top egcd_chk u_chk (.*);
`default_nettype wire
